// ----- design/tree_entry_stream_parser_assert.svh -----
// assertion macros shared by the tree entry stream parser modules
// no dependencies; included by the files that check their own logic
`ifndef TREE_ENTRY_STREAM_PARSER_ASSERT_SVH
`define TREE_ENTRY_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TESP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define TESP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TESP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TESP_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/tesp_pkg.sv -----
// types, codes and helpers for the tree entry stream parser
// no dependencies; imported by every module of the block
package tesp_pkg;

    // parser phase within one entry
    typedef enum logic [1:0] {
        PH_MODE    = 2'd0,
        PH_NAME    = 2'd1,
        PH_ID      = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_ID    = 2'd1;
    localparam logic [1:0] KIND_ENTRY = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // entry types
    localparam logic [1:0] ET_FILE    = 2'd0;
    localparam logic [1:0] ET_DIR     = 2'd1;
    localparam logic [1:0] ET_UNKNOWN = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_DIGIT = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    // characters and mode format bits
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_EIGHT = 8'h38;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [31:0] FMT_MASK   = 32'o170000;
    localparam logic [31:0] FMT_FILE   = 32'o100000;
    localparam logic [31:0] FMT_DIR    = 32'o040000;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // one result transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] entry_mode;
        logic [1:0]  entry_type;
        logic [1:0]  error_code;
    } t_result;

    // results caused by one input byte (one or two)
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_cmd;

    localparam t_result RESULT_ZERO = '0;

    // entry type from the format bits of the mode
    function automatic logic [1:0] type_of(input logic [31:0] mode);
        logic [31:0] f;
        f = mode & FMT_MASK;
        if (f == FMT_FILE) begin
            return ET_FILE;
        end else if (f == FMT_DIR) begin
            return ET_DIR;
        end
        return ET_UNKNOWN;
    endfunction

endpackage

// ----- design/tesp_front.sv -----
// front end: phase tracking and classification of each accepted byte
// depends on tesp_pkg; emits one queue command per byte that has results
module tesp_front import tesp_pkg::*; #(
    parameter int ID_BYTES = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eob,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int CNT_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ID_BYTES - 1);

    t_phase            r_phase, n_phase;
    logic [31:0]       r_acc, n_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic is_digit;
    logic id_last;
    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte < CHAR_EIGHT);
    assign id_last  = (r_cnt == CNT_LAST);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        case (r_phase)
            PH_MODE: begin
                if (i_byte == CHAR_SPACE) begin
                    n_phase = PH_NAME;
                end else if (is_digit) begin
                    n_acc = {r_acc[28:0], i_byte[2:0]};
                end else begin
                    n_phase = PH_DISCARD;
                end
            end
            PH_NAME: begin
                if (i_byte == CHAR_NUL) begin
                    n_phase = PH_ID;
                    n_cnt   = '0;
                end
            end
            PH_ID: begin
                if (id_last) begin
                    n_phase = PH_MODE;
                    n_acc   = '0;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        // end of buffer starts the next buffer afresh
        if (i_eob) begin
            n_phase = PH_MODE;
            n_acc   = '0;
            n_cnt   = '0;
        end
    end

    // results of the byte
    logic    open_entry;
    logic    has0;
    t_result res0, res1;
    t_result trunc;

    always_comb begin
        trunc            = RESULT_ZERO;
        trunc.kind       = KIND_ERROR;
        trunc.error_code = ERR_TRUNCATED;
        res0       = RESULT_ZERO;
        res1       = RESULT_ZERO;
        has0       = 1'b0;
        open_entry = 1'b1;
        o_cmd      = '0;
        case (r_phase)
            PH_MODE: begin
                if (i_byte != CHAR_SPACE && !is_digit) begin
                    has0            = 1'b1;
                    res0.kind       = KIND_ERROR;
                    res0.error_code = ERR_BAD_DIGIT;
                    open_entry      = 1'b0;
                end
            end
            PH_NAME: begin
                if (i_byte != CHAR_NUL) begin
                    has0          = 1'b1;
                    res0.kind     = KIND_NAME;
                    res0.out_byte = i_byte;
                end
            end
            PH_ID: begin
                has0          = 1'b1;
                res0.kind     = KIND_ID;
                res0.out_byte = i_byte;
                if (id_last) begin
                    res1.kind       = KIND_ENTRY;
                    res1.entry_mode = r_acc;
                    res1.entry_type = type_of(r_acc);
                    open_entry      = 1'b0;
                end
            end
            default: begin
                open_entry = 1'b0;
            end
        endcase
        o_push = 1'b0;
        if (has0) begin
            o_push    = i_accept;
            o_cmd.r0  = res0;
            o_cmd.two = (r_phase == PH_ID) && id_last;
            o_cmd.r1  = res1;
            if (i_eob && open_entry) begin
                o_cmd.two = 1'b1;
                o_cmd.r1  = trunc;
            end
        end else if (i_eob && open_entry) begin
            o_push    = i_accept;
            o_cmd.two = 1'b0;
            o_cmd.r0  = trunc;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MODE;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- design/tesp_fifo.sv -----
// short command queue between front and back end
// depends on tesp_pkg and the assertion header
`include "tree_entry_stream_parser_assert.svh"
module tesp_fifo import tesp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // checks
    `TESP_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `TESP_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `TESP_ASSERT(a_level_ptrs, i_clk, i_rst_n, r_wr == r_rd + r_count[QPTR_W-1:0], "level and pointers disagree")

endmodule

// ----- design/tesp_back.sv -----
// back end: expands queued commands into result transfers
// depends on tesp_pkg and the assertion header
`include "tree_entry_stream_parser_assert.svh"
module tesp_back import tesp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_cmd r_cmd;
    logic r_valid;
    logic r_second;
    logic done;
    logic load;

    // current transfer finishes the held command
    assign done     = i_ready && (!r_cmd.two || r_second);
    assign load     = !r_valid || done;
    assign o_pop    = load && !i_empty;
    assign o_valid  = r_valid;
    assign o_result = r_second ? r_cmd.r1 : r_cmd.r0;

    // payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (i_ready) begin
            r_second <= 1'b1;
        end
    end

    // checks
    `TESP_ASSERT(a_second_ok, i_clk, i_rst_n, !r_second || (r_valid && r_cmd.two), "second result without pair")
    `TESP_ASSERT(a_first_then_second, i_clk, i_rst_n, (r_valid && r_cmd.two && !r_second && i_ready) |=> r_second, "second result skipped")

endmodule

// ----- design/tree_entry_stream_parser.sv -----
// top level of the tree entry stream parser: stream ports, front, queue, back
// depends on tesp_pkg, tesp_front, tesp_fifo and tesp_back
//
// Parses a byte stream of tree entries (octal mode, space, name, NUL, ID_BYTES
// id bytes) at one byte per cycle while the four-entry command queue has room.
// Each name or id byte gives one result transfer, the last id byte of an
// entry gives a second one with the mode and type, and a bad mode digit or a
// buffer that ends mid-entry gives an error transfer. The output side issues
// one transfer per cycle while the receiver is ready, so the queue absorbs
// the extra transfer of a byte with two results. Each command is written
// into the queue, then popped into the back end's output register. tlast on
// the input marks the last byte of a buffer and restarts parsing.
module tree_entry_stream_parser import tesp_pkg::*; #(
    parameter int ID_BYTES = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_buffer
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] out_byte, [39:8] entry_mode,
                                          // [41:40] entry_type, [43:42] error_code
    output logic [1:0]  o_m_axis_tuser    // kind
);

    logic    accept;
    logic    push, pop, full, empty;
    t_cmd    push_cmd, head_cmd;
    t_result res;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // classification
    tesp_front #(.ID_BYTES(ID_BYTES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_eob    (i_s_axis_tlast),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // command queue
    tesp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // result issue
    tesp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    // output packing
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tdata = {4'b0000, res.error_code, res.entry_type,
                             res.entry_mode, res.out_byte};

endmodule

// ----- tb/tb_tree_entry_stream_parser.sv -----
// testbench for tree_entry_stream_parser: directed table, then random tree buffers
// depends on tesp_pkg and tree_entry_stream_parser; self-checking against its own parser model
`timescale 1ns / 100ps

module tb_tree_entry_stream_parser import tesp_pkg::*; ();

    localparam int ID_BYTES    = 20;
    localparam int ITEM_TARGET = 650;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;

    // one row of the directed table; n_typed < 0 means the parser model decides
    typedef struct {
        logic [7:0] d;
        logic       eob;
        int         n_typed;
        t_result    e0;
        t_result    e1;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    // parser model state
    t_phase      pred_phase = PH_MODE;
    logic [31:0] pred_mode = '0;
    logic [4:0]  pred_idx = '0;

    t_result     results_due[$];
    t_script_row script[$];
    int          mismatches = 0;
    int          n_sent = 0;
    int          cycles = 0;
    bit          held = 1'b0;
    int          send_burst = 0;

    tree_entry_stream_parser #(
        .ID_BYTES (ID_BYTES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),          // [7:0] data_byte
        .i_s_axis_tlast  (s_last),          // end_of_buffer
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [7:0] out_byte, [39:8] entry_mode,
                                            // [41:40] entry_type, [43:42] error_code
        .o_m_axis_tuser  (o_m_axis_tuser)   // kind
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result builders
    function automatic t_result byte_result(input logic [1:0] kind, input logic [7:0] b);
        t_result r;
        r = RESULT_ZERO;
        r.kind = kind;
        r.out_byte = b;
        return r;
    endfunction

    function automatic t_result entry_result(input logic [31:0] mode, input logic [1:0] ty);
        t_result r;
        r = RESULT_ZERO;
        r.kind = KIND_ENTRY;
        r.entry_mode = mode;
        r.entry_type = ty;
        return r;
    endfunction

    function automatic t_result error_result(input logic [1:0] code);
        t_result r;
        r = RESULT_ZERO;
        r.kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    // parser model: one byte in, up to two results out
    function automatic int parse_byte(input logic [7:0] d, input logic eob,
                                      output t_result r0, output t_result r1);
        t_result     got[2];
        int          n;
        logic        open;
        logic [31:0] fmt;
        logic [1:0]  ty;
        n = 0;
        open = 1'b1;
        got[0] = RESULT_ZERO;
        got[1] = RESULT_ZERO;
        case (pred_phase)
            PH_MODE: begin
                if (d == CHAR_SPACE) begin
                    pred_phase = PH_NAME;
                end else if (d >= CHAR_ZERO && d < CHAR_EIGHT) begin
                    pred_mode = {pred_mode[28:0], d[2:0]};
                end else begin
                    got[n] = error_result(ERR_BAD_DIGIT);
                    n++;
                    pred_phase = PH_DISCARD;
                    open = 1'b0;
                end
            end
            PH_NAME: begin
                if (d == CHAR_NUL) begin
                    pred_phase = PH_ID;
                    pred_idx = '0;
                end else begin
                    got[n] = byte_result(KIND_NAME, d);
                    n++;
                end
            end
            PH_ID: begin
                got[n] = byte_result(KIND_ID, d);
                n++;
                if (int'(pred_idx) + 1 >= ID_BYTES) begin
                    // format bits pick the entry type
                    fmt = pred_mode & FMT_MASK;
                    if (fmt == FMT_FILE) ty = ET_FILE;
                    else if (fmt == FMT_DIR) ty = ET_DIR;
                    else ty = ET_UNKNOWN;
                    got[n] = entry_result(pred_mode, ty);
                    n++;
                    pred_phase = PH_MODE;
                    pred_mode = '0;
                    pred_idx = '0;
                    open = 1'b0;
                end else begin
                    pred_idx = pred_idx + 5'd1;
                end
            end
            default: begin
                open = 1'b0;
            end
        endcase
        // end of buffer restarts parsing, reporting an unfinished entry
        if (eob) begin
            if (open) begin
                got[n] = error_result(ERR_TRUNCATED);
                n++;
            end
            pred_phase = PH_MODE;
            pred_mode = '0;
            pred_idx = '0;
        end
        r0 = got[0];
        r1 = got[1];
        return n;
    endfunction

    // idle length: mostly none or short, a few long, with idle-free stretches
    function automatic int pick_gap(ref int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic eob, input int n_typed,
                                    input t_result e0, input t_result e1);
        t_script_row row;
        row.d = d;
        row.eob = eob;
        row.n_typed = n_typed;
        row.e0 = e0;
        row.e1 = e1;
        script.push_back(row);
    endfunction

    // offer one byte, wait for its transfer, then record what it should give
    task automatic send_byte(input logic [7:0] d, input logic eob, input int n_typed,
                             input t_result e0, input t_result e1);
        t_result p0;
        t_result p1;
        int      n;
        int      g;
        g = pick_gap(send_burst);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        s_last <= eob;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (pred_phase != PH_DISCARD) n_sent++;
        n = parse_byte(d, eob, p0, p1);
        if (n_typed < 0) begin
            if (n > 0) results_due.push_back(p0);
            if (n > 1) results_due.push_back(p1);
        end else begin
            if (n_typed > 0) results_due.push_back(e0);
            if (n_typed > 1) results_due.push_back(e1);
        end
    endtask

    // one well-formed entry: octal mode, space, name, NUL, id bytes
    task automatic append_entry(ref logic [7:0] q[$]);
        logic [63:0] m;
        int          nd;
        case ($urandom_range(0, 7))
            0: begin m = 64'(FMT_FILE | 32'o644); nd = 6; end
            1: begin m = 64'(FMT_FILE | 32'o755); nd = 6; end
            2: begin m = 64'(FMT_DIR); nd = $urandom_range(5, 6); end
            3: begin m = 64'o120000; nd = 6; end
            4: begin m = 64'o160000; nd = 6; end
            5: begin m = 64'($urandom); nd = $urandom_range(1, 11); end
            6: begin m = '0; nd = 0; end
            default: begin m = {$urandom, $urandom}; nd = $urandom_range(12, 21); end
        endcase
        for (int i = nd - 1; i >= 0; i--) begin
            q.push_back(8'(CHAR_ZERO + ((m >> (3 * i)) & 64'd7)));
        end
        q.push_back(CHAR_SPACE);
        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(1, 255)));
        q.push_back(CHAR_NUL);
        repeat (ID_BYTES) q.push_back(8'($urandom_range(0, 255)));
    endtask

    // one buffer: mostly whole entries, some with a bad digit, cut short or pure noise
    task automatic random_buffer();
        logic [7:0] q[$];
        logic [7:0] part[$];
        logic [7:0] bad;
        int         f;
        int         n;
        f = $urandom_range(0, 19);
        if (f == 0) begin
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 3)) append_entry(q);
            if (f <= 3) begin
                repeat ($urandom_range(0, 4)) q.push_back(8'(CHAR_ZERO + $urandom_range(0, 7)));
                do begin
                    bad = 8'($urandom_range(0, 255));
                end while (bad == CHAR_SPACE || (bad >= CHAR_ZERO && bad < CHAR_EIGHT));
                q.push_back(bad);
                repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(0, 255)));
            end else if (f <= 6) begin
                append_entry(part);
                n = $urandom_range(1, part.size() - 1);
                for (int i = 0; i < n; i++) q.push_back(part[i]);
            end
        end
        foreach (q[i]) begin
            send_byte(q[i], i == q.size() - 1, -1, RESULT_ZERO, RESULT_ZERO);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial begin
        // bad digits, discard, truncation in the mode and id phases, name extremes
        add_row(8'h2f, 1'b0, 1, error_result(ERR_BAD_DIGIT), RESULT_ZERO);
        add_row(8'hff, 1'b1, 0, RESULT_ZERO, RESULT_ZERO);
        add_row(CHAR_EIGHT, 1'b1, 1, error_result(ERR_BAD_DIGIT), RESULT_ZERO);
        add_row(CHAR_ZERO, 1'b1, 1, error_result(ERR_TRUNCATED), RESULT_ZERO);
        add_row(CHAR_SPACE, 1'b0, 0, RESULT_ZERO, RESULT_ZERO);
        add_row(8'hff, 1'b0, 1, byte_result(KIND_NAME, 8'hff), RESULT_ZERO);
        add_row(8'h01, 1'b0, 1, byte_result(KIND_NAME, 8'h01), RESULT_ZERO);
        add_row(CHAR_NUL, 1'b0, 0, RESULT_ZERO, RESULT_ZERO);
        add_row(8'h00, 1'b1, 2, byte_result(KIND_ID, 8'h00), error_result(ERR_TRUNCATED));
        // empty mode, empty name, clean end on the last id byte
        add_row(CHAR_SPACE, 1'b0, 0, RESULT_ZERO, RESULT_ZERO);
        add_row(CHAR_NUL, 1'b0, 0, RESULT_ZERO, RESULT_ZERO);
        for (int i = 0; i < ID_BYTES - 1; i++) begin
            add_row(i[0] ? 8'h00 : 8'hff, 1'b0, -1, RESULT_ZERO, RESULT_ZERO);
        end
        add_row(8'h5a, 1'b1, 2, byte_result(KIND_ID, 8'h5a), entry_result('0, ET_UNKNOWN));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            send_byte(script[i].d, script[i].eob, script[i].n_typed, script[i].e0, script[i].e1);
        end
        n_sent = 0;
        while (n_sent < ITEM_TARGET) random_buffer();
        s_valid <= 1'b0;
        s_last <= 1'b0;

        // drain, then allow for anything late
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // receiver stalls, with one long hold-off so the block backs up
    initial begin
        int len;
        int burst;
        burst = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_sent >= HOLD_AFTER && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                len = pick_gap(burst);
                if (len == 0) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (len) @(posedge i_clk);
                end
            end
        end
    end

    // result transfer check
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none actual kind %h tdata %h",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_axis_tuser));
                check_field("out_byte", 32'(want.out_byte), 32'(o_m_axis_tdata[7:0]));
                check_field("entry_mode", want.entry_mode, o_m_axis_tdata[39:8]);
                check_field("entry_type", 32'(want.entry_type), 32'(o_m_axis_tdata[41:40]));
                check_field("error_code", 32'(want.error_code), 32'(o_m_axis_tdata[43:42]));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/tesp_pkg.sv
design/tesp_front.sv
design/tesp_fifo.sv
design/tesp_back.sv
design/tree_entry_stream_parser.sv
tb/tb_tree_entry_stream_parser.sv
